// ===== rtl/lifo_preemptive_scheduler_assert.svh =====
// Assertion macros used by the checker of the LIFO preemptive scheduler.
`ifndef LIFO_PREEMPTIVE_SCHEDULER_ASSERT_SVH
`define LIFO_PREEMPTIVE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on the block clock, idle while in reset.
`define LPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lifo scheduler: same-cycle check failed");

// Next-cycle implication, sampled on the block clock, idle while in reset.
`define LPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lifo scheduler: next-cycle check failed");

`endif

// ===== rtl/lps_pkg.sv =====
// Shared types, constants and the microcode table of the LIFO preemptive scheduler.
`default_nettype none
package lps_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ARR_W      = 16;
  localparam int unsigned BURST_W    = 16;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned STEP_W     = 3;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT   = 3'd0;
  localparam step_t STEP_SCAN   = 3'd1;
  localparam step_t STEP_DRAIN  = 3'd2;
  localparam step_t STEP_RDPICK = 3'd3;
  localparam step_t STEP_UPD    = 3'd4;
  localparam step_t STEP_WT     = 3'd5;
  localparam step_t STEP_EMIT   = 3'd6;

  // Input word kinds carried on the slave tuser bit.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_NOT_TICK  = 3'd1,
    COND_SCAN_MORE = 3'd2,
    COND_NO_PICK   = 3'd3,
    COND_OUT_BUSY  = 3'd4
  } cond_e;

  typedef struct packed {
    logic  in_rdy;
    logic  scan;
    logic  drain;
    logic  now_inc;
    logic  rd_pick;
    logic  upd;
    logic  wt_calc;
    logic  emit;
    logic  ret;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic tick_acc;
    logic scan_more;
    logic no_pick;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic                  busy;
    logic [SLOT_OUT_W-1:0] run_slot;
    logic                  finished;
    logic [TIME_W-1:0]     completion;
    logic [TIME_W-1:0]     turnaround;
    logic [TIME_W-1:0]     waiting;
    logic                  all_done;
  } result_t;

  // Control store: one word per step. A taken jump goes to target; otherwise the
  // sequencer falls through to the next step, or back to the wait step when ret is set.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w        = '0;
    w.cond   = COND_NEVER;
    w.target = STEP_WAIT;
    case (step)
      STEP_WAIT: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_NOT_TICK;
        w.target = STEP_WAIT;
      end
      STEP_SCAN: begin
        w.scan   = 1'b1;
        w.cond   = COND_SCAN_MORE;
        w.target = STEP_SCAN;
      end
      STEP_DRAIN: begin
        w.drain   = 1'b1;
        w.now_inc = 1'b1;
      end
      STEP_RDPICK: begin
        w.rd_pick = 1'b1;
        w.cond    = COND_NO_PICK;
        w.target  = STEP_EMIT;
      end
      STEP_UPD: begin
        w.upd     = 1'b1;
        w.rd_pick = 1'b1;
      end
      STEP_WT: begin
        w.wt_calc = 1'b1;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.ret    = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      default: begin
        w.ret = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lps_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none
module lps_seq import lps_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  step_t pc_q, pc_d;
  logic  taken;

  assign ctrl_o = ucode(pc_q);

  always_comb begin
    case (ctrl_o.cond)
      COND_NEVER:     taken = 1'b0;
      COND_NOT_TICK:  taken = !stat_i.tick_acc;
      COND_SCAN_MORE: taken = stat_i.scan_more;
      COND_NO_PICK:   taken = stat_i.no_pick;
      COND_OUT_BUSY:  taken = stat_i.out_busy;
      default:        taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_d = ctrl_o.target;
    end else if (ctrl_o.ret) begin
      pc_d = STEP_WAIT;
    end else begin
      pc_d = pc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lps_dp.sv =====
// Datapath: job tables, slot scan, remaining-time update and result registers.
`default_nettype none
module lps_dp import lps_pkg::*; #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  ctrl_t              ctrl_i,
  input  wire                in_accept_i,
  input  wire                op_i,
  input  wire  [ARR_W-1:0]   arrival_i,
  input  wire  [BURST_W-1:0] burst_i,
  input  wire                out_busy_i,
  output stat_t              stat_o,
  output result_t            res_o
);

  localparam int unsigned SLOT_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_JOBS + 1);

  logic [ARR_W-1:0]   arr_mem   [MAX_JOBS];
  logic [BURST_W-1:0] burst_mem [MAX_JOBS];
  logic [BURST_W-1:0] rem_mem   [MAX_JOBS];

  logic [ARR_W-1:0]    arr_rd_q;
  logic [BURST_W-1:0]  burst_rd_q;
  logic [BURST_W-1:0]  rem_rd_q;

  logic [CNT_W-1:0]    loaded_q, fin_cnt_q, idx_q;
  logic [TIME_W-1:0]   now_q;
  logic [MAX_JOBS-1:0] done_q;
  logic                rd_v_q, pick_v_q, fin_q;
  logic [SLOT_W-1:0]   rd_slot_q, pick_q;
  logic [ARR_W-1:0]    best_q;
  logic [TIME_W-1:0]   tat_q, wt_q;

  logic                load_wr, tick_acc, scan_issue, eval_en, arr_le_now, take, upd_fin;
  logic [SLOT_W-1:0]   load_slot, rd_addr;
  logic [BURST_W-1:0]  burst_fix, rem_dec;
  logic [CNT_W:0]      idx_inc;
  logic [TIME_W-1:0]   tat_d, wt_d, burst_ext;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

  assign tick_acc   = in_accept_i && (op_i == OP_TICK);
  assign load_wr    = in_accept_i && (op_i == OP_LOAD) && (loaded_q < CNT_W'(MAX_JOBS));
  assign load_slot  = loaded_q[SLOT_W-1:0];
  assign burst_fix  = (burst_i == '0) ? BURST_W'(1) : burst_i;

  assign scan_issue = ctrl_i.scan && (idx_q < loaded_q);
  assign idx_inc    = {1'b0, idx_q} + (CNT_W+1)'(1);
  assign rd_addr    = ctrl_i.rd_pick ? pick_q : idx_q[SLOT_W-1:0];

  // A slot is eligible once it has arrived by the current time and is not done;
  // ">=" lets a later slot with the same arrival win the tie.
  assign eval_en    = rd_v_q && (ctrl_i.scan || ctrl_i.drain);
  assign arr_le_now = (now_q[TIME_W-1:ARR_W] != '0) || (arr_rd_q <= now_q[ARR_W-1:0]);
  assign take       = eval_en && !done_q[rd_slot_q] && arr_le_now &&
                      (!pick_v_q || (arr_rd_q >= best_q));

  assign rem_dec    = rem_rd_q - BURST_W'(1);
  assign upd_fin    = ctrl_i.upd && (rem_dec == '0);
  assign tat_d      = now_q - TIME_W'(arr_rd_q);
  assign burst_ext  = TIME_W'(burst_rd_q);
  assign wt_d       = (tat_q >= burst_ext) ? (tat_q - burst_ext) : '0;

  assign stat_o.tick_acc  = tick_acc;
  assign stat_o.scan_more = idx_inc < {1'b0, loaded_q};
  assign stat_o.no_pick   = !pick_v_q;
  assign stat_o.out_busy  = out_busy_i;

  assign slot_wide         = {{SLOT_OUT_W{1'b0}}, pick_q};
  assign res_o.busy        = pick_v_q;
  assign res_o.run_slot    = pick_v_q ? slot_wide[SLOT_OUT_W-1:0] : '0;
  assign res_o.finished    = fin_q;
  assign res_o.completion  = fin_q ? now_q : '0;
  assign res_o.turnaround  = fin_q ? tat_q : '0;
  assign res_o.waiting     = fin_q ? wt_q : '0;
  assign res_o.all_done    = (fin_cnt_q == loaded_q);

  // Job tables: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      arr_mem[load_slot]   <= arrival_i;
      burst_mem[load_slot] <= burst_fix;
    end
    if (ctrl_i.upd) begin
      rem_mem[pick_q] <= rem_dec;
    end else if (load_wr) begin
      rem_mem[load_slot] <= burst_fix;
    end
    arr_rd_q   <= arr_mem[rd_addr];
    burst_rd_q <= burst_mem[rd_addr];
    rem_rd_q   <= rem_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q  <= '0;
      fin_cnt_q <= '0;
      idx_q     <= '0;
      now_q     <= '0;
      done_q    <= '0;
      rd_v_q    <= 1'b0;
      pick_v_q  <= 1'b0;
      fin_q     <= 1'b0;
    end else begin
      rd_v_q <= scan_issue;
      if (load_wr) begin
        loaded_q          <= loaded_q + CNT_W'(1);
        done_q[load_slot] <= 1'b0;
      end
      if (tick_acc) begin
        idx_q    <= '0;
        pick_v_q <= 1'b0;
        fin_q    <= 1'b0;
      end
      if (scan_issue) begin
        idx_q <= idx_inc[CNT_W-1:0];
      end
      if (take) begin
        pick_v_q <= 1'b1;
      end
      if (ctrl_i.now_inc && (now_q != '1)) begin
        now_q <= now_q + TIME_W'(1);
      end
      if (upd_fin) begin
        fin_q          <= 1'b1;
        done_q[pick_q] <= 1'b1;
        fin_cnt_q      <= fin_cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q <= idx_q[SLOT_W-1:0];
    if (take) begin
      pick_q <= rd_slot_q;
      best_q <= arr_rd_q;
    end
    if (upd_fin) begin
      tat_q <= tat_d;
    end
    if (ctrl_i.wt_calc) begin
      wt_q <= wt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lifo_preemptive_scheduler.sv =====
// Top level of the LIFO preemptive scheduler.
// Sequence: a tick word runs a scan over the loaded slots, one slot per cycle, then, when a
//   job was picked, the update of that job, and its result is then emitted; a load gives none.
// Flow: no new word is taken while a tick is in work, and a finished result waits while the
//   output register is full; load words can be taken back to back.
// Reset: asynchronous, active low; clears all control state but not the job tables.
`default_nettype none
module lifo_preemptive_scheduler import lps_pkg::*; #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: arrival_time[15:0], burst_length[31:16].
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: operation (0 loads a job, 1 is a time tick).
  input  wire                   s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // Fields from bit 0: run_slot[3:0], finished[4], completion_tick[36:5],
  // turnaround[68:37], waiting[100:69], all_done[101], zero fill[103:102].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: busy_res (1 when a job ran in this tick, 0 when idle).
  output logic                  m_axis_tuser
);

  // The sequencer walks a short control store. It waits for a word; a load is
  // written into the tables in that same cycle, while a tick starts a scan over the
  // loaded slots, one table read per cycle, keeping the latest eligible arrival.
  // After the scan time steps forward, the chosen job's remaining time is read back,
  // decremented and, when it hits zero, its turnaround and waiting time are formed.
  ctrl_t   ctrl;
  stat_t   stat;
  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    in_accept;
  logic    out_busy;
  logic    emit_fire;

  assign s_axis_tready = ctrl.in_rdy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // The output register frees the sequencer to take the next word while a result
  // still waits downstream; a new result only holds while the slot is occupied.
  assign out_busy  = out_valid_q && !m_axis_tready;
  assign emit_fire = ctrl.emit && !out_busy;

  lps_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  lps_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_accept_i (in_accept),
    .op_i        (s_axis_tuser),
    .arrival_i   (s_axis_tdata[ARR_W-1:0]),
    .burst_i     (s_axis_tdata[ARR_W+BURST_W-1:ARR_W]),
    .out_busy_i  (out_busy),
    .stat_o      (stat),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.busy;
  assign m_axis_tdata  = {2'b00, out_q.all_done, out_q.waiting, out_q.turnaround,
                          out_q.completion, out_q.finished, out_q.run_slot};

endmodule
`default_nettype wire

// ===== rtl/lps_chk.sv =====
// Port-level checker for the LIFO preemptive scheduler, bound to the top level.
`default_nettype none
`include "lifo_preemptive_scheduler_assert.svh"
module lps_chk import lps_pkg::*; (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  s_axis_tvalid,
  input wire                  s_axis_tready,
  input wire                  s_axis_tuser,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire [OUT_DATA_W-1:0] m_axis_tdata,
  input wire                  m_axis_tuser
);

  // A result that was not taken stays on the bus unchanged.
  `LPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Taking a tick word starts the scan, so the input side closes in the next cycle.
  `LPS_ASSERT_NEXT(a_tick_closes_input, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)

  // An idle tick names no slot and finishes nothing.
  `LPS_ASSERT_NOW(a_idle_clean, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[4:0] == 5'd0)

  // A completion only comes from a job that ran, and waiting never exceeds turnaround.
  `LPS_ASSERT_NOW(a_finish_sane, m_axis_tvalid && m_axis_tdata[4], m_axis_tuser && (m_axis_tdata[100:69] <= m_axis_tdata[68:37]))

endmodule

bind lifo_preemptive_scheduler lps_chk u_lps_chk (.*);
`default_nettype wire
